[rtl/tkq_pkg.sv]
// Package with constants, codes and the control/status types of the top-K queue depth recorder.
package tkq_pkg;

    localparam int MAX_ENTRIES = 4;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int DEPTH_W     = 16;
    localparam int DIV_CNT_W   = $clog2(DEPTH_W);
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 16;

    localparam logic [1:0] STATUS_REJECT = 2'd0;
    localparam logic [1:0] STATUS_SKIP   = 2'd1;
    localparam logic [1:0] STATUS_RECORD = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic scan_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic scan_last;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/tkq_ctrl.sv]
// Controller state machine that sequences divide, scan and table update for one report.
module tkq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tkq_pkg::dp_sts_t sts,
    output tkq_pkg::dp_cmd_t cmd
);
    import tkq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/tkq_datapath.sv]
// Datapath with the restoring divider, the entry table, the minimum scan and the result register.
module tkq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [tkq_pkg::DEPTH_W-1:0]   cfg_data,
    input  logic                          in_clear,
    input  logic [tkq_pkg::IN_DATA_W-1:0] in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tkq_pkg::OUT_DATA_W-1:0] out_data,
    input  tkq_pkg::dp_cmd_t              cmd,
    output tkq_pkg::dp_sts_t              sts
);
    import tkq_pkg::*;

    logic [DEPTH_W-1:0]   unit_reg;
    logic [7:0]           node_reg;
    logic [7:0]           port_reg;
    logic [31:0]          time_reg;
    logic [7:0]           rate_reg;
    logic [DEPTH_W-1:0]   rem_reg;
    logic [DEPTH_W-1:0]   quot_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     min_idx_reg;
    logic [DEPTH_W:0]     min_val_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [7:0]         ent_node_reg  [MAX_ENTRIES];
    logic [7:0]         ent_port_reg  [MAX_ENTRIES];
    logic [DEPTH_W-1:0] ent_depth_reg [MAX_ENTRIES];
    logic [31:0]        ent_time_reg  [MAX_ENTRIES];
    logic [7:0]         ent_rate_reg  [MAX_ENTRIES];

    logic [DEPTH_W+1:0] diff;
    logic               borrow;
    logic [DEPTH_W:0]   scan_val;
    logic               table_full;
    logic               do_write;
    logic [IDX_W-1:0]   wr_idx;
    logic [1:0]         status;
    logic [5:0]         slot;

    // A zero divisor never borrows, so the quotient comes out as all ones.
    assign diff   = {1'b0, rem_reg, quot_reg[DEPTH_W-1]} - {2'b00, unit_reg};
    assign borrow = diff[DEPTH_W+1];

    assign scan_val   = {1'b0, ent_depth_reg[scan_idx_reg]};
    assign table_full = (count_reg == COUNT_W'(MAX_ENTRIES));

    always_comb
    begin
        do_write   = 1'b0;
        wr_idx     = min_idx_reg;
        status     = STATUS_SKIP;
        slot       = '0;
        count_next = count_reg;
        if (quot_reg == '0)
        begin
            status = STATUS_REJECT;
        end
        else if (!table_full)
        begin
            do_write   = 1'b1;
            wr_idx     = count_reg[IDX_W-1:0];
            status     = STATUS_RECORD;
            slot       = 6'(count_reg[IDX_W-1:0]);
            count_next = count_reg + COUNT_W'(1);
        end
        else if ({1'b0, quot_reg} > min_val_reg)
        begin
            do_write = 1'b1;
            status   = STATUS_RECORD;
            slot     = 6'(min_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg      <= DEPTH_W'(1);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unit_reg <= cfg_data;
            end
            if (cmd.load && in_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            node_reg     <= in_data[7:0];
            port_reg     <= in_data[15:8];
            quot_reg     <= in_data[31:16];
            time_reg     <= in_data[63:32];
            rate_reg     <= in_data[71:64];
            rem_reg      <= '0;
            div_cnt_reg  <= '0;
            scan_idx_reg <= '0;
            min_idx_reg  <= '0;
            min_val_reg  <= {1'b1, {DEPTH_W{1'b0}}};
        end
        if (cmd.div_step)
        begin
            rem_reg     <= borrow ? {rem_reg[DEPTH_W-2:0], quot_reg[DEPTH_W-1]}
                                  : diff[DEPTH_W-1:0];
            quot_reg    <= {quot_reg[DEPTH_W-2:0], ~borrow};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.scan_step)
        begin
            if (scan_val < min_val_reg)
            begin
                min_val_reg <= scan_val;
                min_idx_reg <= scan_idx_reg;
            end
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (cmd.finish)
        begin
            out_data_reg <= {1'b0, 7'(count_next), slot, status};
            if (do_write)
            begin
                ent_node_reg[wr_idx]  <= node_reg;
                ent_port_reg[wr_idx]  <= port_reg;
                ent_depth_reg[wr_idx] <= quot_reg;
                ent_time_reg[wr_idx]  <= time_reg;
                ent_rate_reg[wr_idx]  <= rate_reg;
            end
        end
    end

    assign sts.div_last  = (div_cnt_reg == DIV_CNT_W'(DEPTH_W - 1));
    assign sts.scan_last = (scan_idx_reg == IDX_W'(MAX_ENTRIES - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/top_k_queue_depth_recorder.sv]
// Top level of the top-K queue depth recorder, joining controller and datapath.
//
// Channel   Direction  Handshake              Payload
// s_axis    in         s_tvalid / s_tready    hop report, clear flag in tuser
// m_axis    out        m_tvalid / m_tready    status, slot, used entry count
// cfg       in         cfg_valid / cfg_ready  depth unit divisor
//
// A report occupies the controller from the accepting cycle, which loads it, through the
// bit-serial divider and the minimum scan over every table entry to the table update.
// The next report is accepted in the cycle after the result is registered.
// Reset empties the table and sets the depth unit to one; cfg_ready is always high.
// A stalled result holds in the output register and only blocks the update of the next report.
module top_k_queue_depth_recorder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: node_id, port_num, raw_depth, time_stamp, rate_code.
    input  logic [tkq_pkg::IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: clear_first.
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: status, slot, used_entries, one zero pad bit.
    output logic [tkq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tkq_pkg::DEPTH_W-1:0]    cfg_data
);
    import tkq_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    tkq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tkq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_clear  (s_tuser),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[dv/top_k_queue_depth_recorder_tb.sv]
// Self-checking testbench for the top-K queue depth recorder with a scoreboard class.
`timescale 1ns / 100ps

module top_k_queue_depth_recorder_tb;

    import tkq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 230;

    typedef struct packed {
        logic        clear_first;
        logic [7:0]  node_id;
        logic [7:0]  port_num;
        logic [15:0] raw_depth;
        logic [31:0] time_stamp;
        logic [7:0]  rate_code;
    } report_t;

    typedef struct packed {
        logic [6:0] used_entries;
        logic [5:0] slot;
        logic [1:0] status;
    } result_t;

    class depth_record_checker;
        logic [15:0] unit;
        int          count;
        logic [7:0]  node_tab  [MAX_ENTRIES];
        logic [7:0]  port_tab  [MAX_ENTRIES];
        logic [15:0] depth_tab [MAX_ENTRIES];
        logic [31:0] time_tab  [MAX_ENTRIES];
        logic [7:0]  rate_tab  [MAX_ENTRIES];
        result_t     pending_results[$];
        int          mismatches;

        function new();
            unit = 16'd1;
            mismatches = 0;
            wipe_table();
        endfunction

        function void wipe_table();
            count = 0;
            foreach (depth_tab[i])
            begin
                node_tab[i]  = '0;
                port_tab[i]  = '0;
                depth_tab[i] = '0;
                time_tab[i]  = '0;
                rate_tab[i]  = '0;
            end
        endfunction

        function void set_unit(logic [15:0] value);
            unit = value;
        endfunction

        function void store_entry(int idx, report_t r, logic [15:0] scaled);
            node_tab[idx]  = r.node_id;
            port_tab[idx]  = r.port_num;
            depth_tab[idx] = scaled;
            time_tab[idx]  = r.time_stamp;
            rate_tab[idx]  = r.rate_code;
        endfunction

        function void note_report(report_t r);
            logic [15:0] scaled;
            logic [15:0] low_val;
            int          low_idx;
            result_t     res;
            if (r.clear_first)
                wipe_table();
            scaled = (unit == 16'd0) ? 16'hffff : r.raw_depth / unit;
            res.status = STATUS_SKIP;
            res.slot = '0;
            if (scaled == 16'd0)
            begin
                res.status = STATUS_REJECT;
            end
            else if (count < MAX_ENTRIES)
            begin
                res.slot = 6'(count);
                store_entry(count, r, scaled);
                count++;
                res.status = STATUS_RECORD;
            end
            else
            begin
                low_idx = 0;
                low_val = depth_tab[0];
                for (int i = 1; i < MAX_ENTRIES; i++)
                begin
                    if (depth_tab[i] < low_val)
                    begin
                        low_val = depth_tab[i];
                        low_idx = i;
                    end
                end
                if (scaled > low_val)
                begin
                    res.slot = 6'(low_idx);
                    store_entry(low_idx, r, scaled);
                    res.status = STATUS_RECORD;
                end
            end
            res.used_entries = 7'(count);
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            result_t got;
            result_t want;
            got = data[14:0];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d slot %0d used %0d",
                             got.status, got.slot, got.used_entries);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: status %0d/%0d slot %0d/%0d used %0d/%0d",
                                 want.status, got.status, want.slot, got.slot,
                                 want.used_entries, got.used_entries);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [DEPTH_W-1:0]    cfg_data;

    depth_record_checker sb;
    report_t             stim_q[$];
    bit                  tx_burst;
    bit                  rx_burst;
    int                  cycle_count;

    top_k_queue_depth_recorder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cycle_count = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        sb = new();
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic void push_report(logic clear, logic [7:0] node, logic [7:0] port,
                                        logic [15:0] raw, logic [31:0] ts, logic [7:0] rate);
        report_t r;
        r.clear_first = clear;
        r.node_id = node;
        r.port_num = port;
        r.raw_depth = raw;
        r.time_stamp = ts;
        r.rate_code = rate;
        stim_q.push_back(r);
    endfunction

    function automatic void build_random_phase(int n);
        logic [15:0] raw;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0: raw = 16'd0;
                1: raw = 16'hffff;
                2, 3: raw = 16'($urandom_range(0, 255));
                default: raw = 16'($urandom);
            endcase
            push_report($urandom_range(0, 9) == 0, 8'($urandom), 8'($urandom), raw,
                        $urandom, 8'($urandom));
        end
    endfunction

    task automatic drive_reports();
        int gap;
        int next_gap;
        int tx_count;
        tx_count = 0;
        gap = draw_wait(tx_burst);
        for (int i = 0; i < stim_q.size(); i++)
        begin
            if (gap > 0)
                repeat (gap) @(posedge clk);
            s_tvalid <= 1'b1;
            s_tuser <= stim_q[i].clear_first;
            s_tdata <= {stim_q[i].rate_code, stim_q[i].time_stamp, stim_q[i].raw_depth,
                        stim_q[i].port_num, stim_q[i].node_id};
            do
                @(posedge clk);
            while (!s_tready);
            sb.note_report(stim_q[i]);
            tx_count++;
            if (tx_count % 40 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            next_gap = draw_wait(tx_burst);
            if (i == stim_q.size() - 1 || next_gap > 0)
                s_tvalid <= 1'b0;
            gap = next_gap;
        end
        stim_q.delete();
    endtask

    task automatic write_unit(logic [15:0] value);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_unit(value);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int w;
        int rx_count;
        rx_count = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            w = draw_wait(rx_burst);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata);
            rx_count++;
            if (rx_count % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        logic [15:0] units [8];
        units = '{16'd3, 16'd0, 16'd65535, 16'd1, 16'd200, 16'd12, 16'd40000, 16'd1};
        units[5] = 16'($urandom_range(1, 65535));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The table fills, then ties, equal depths and replacement are exercised.
        push_report(1'b1, 8'h00, 8'h00, 16'd0,     32'h0000_0000, 8'h00);
        push_report(1'b0, 8'hff, 8'hff, 16'hffff,  32'hffff_ffff, 8'hff);
        push_report(1'b0, 8'hff, 8'h00, 16'd5,     32'h0000_0000, 8'hff);
        push_report(1'b0, 8'h00, 8'hff, 16'd5,     32'hffff_ffff, 8'h00);
        push_report(1'b0, 8'h5a, 8'ha5, 16'd9,     32'h5555_aaaa, 8'h5a);
        push_report(1'b0, 8'h01, 8'h02, 16'd5,     32'h0000_0001, 8'h03);
        push_report(1'b0, 8'h10, 8'h20, 16'd6,     32'h1234_5678, 8'h40);
        push_report(1'b0, 8'h11, 8'h21, 16'd1,     32'h8765_4321, 8'h41);
        push_report(1'b0, 8'h12, 8'h22, 16'd0,     32'hdead_beef, 8'h42);
        push_report(1'b1, 8'h13, 8'h23, 16'd1,     32'h0bad_f00d, 8'h43);
        drive_reports();

        // A zero divisor makes every report maximally deep.
        write_unit(16'd0);
        push_report(1'b0, 8'h21, 8'h31, 16'd0,     32'h0000_00ff, 8'h81);
        push_report(1'b1, 8'h22, 8'h32, 16'hffff,  32'hff00_0000, 8'h82);
        push_report(1'b0, 8'h23, 8'h33, 16'h8000,  32'h0f0f_0f0f, 8'h83);
        drive_reports();

        write_unit(16'd65535);
        push_report(1'b1, 8'h31, 8'h41, 16'd65534, 32'h0000_0002, 8'h91);
        push_report(1'b0, 8'h32, 8'h42, 16'd65535, 32'h0000_0003, 8'h92);
        push_report(1'b0, 8'h33, 8'h43, 16'd1,     32'h0000_0004, 8'h93);
        drive_reports();

        write_unit(16'd2);
        push_report(1'b0, 8'h41, 8'h51, 16'd1,     32'h0000_0005, 8'ha1);
        push_report(1'b0, 8'h42, 8'h52, 16'd3,     32'h0000_0006, 8'ha2);
        push_report(1'b0, 8'h43, 8'h53, 16'd4,     32'h0000_0007, 8'ha3);
        push_report(1'b0, 8'h44, 8'h54, 16'd2,     32'h0000_0008, 8'ha4);
        push_report(1'b0, 8'h45, 8'h55, 16'd5,     32'h0000_0009, 8'ha5);
        drive_reports();

        foreach (units[p])
        begin
            write_unit(units[p]);
            build_random_phase(PHASE_ITEMS);
            drive_reports();
        end

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
